[hw/rtl/itmq_pkg.sv]
//------------------------------------------------------------------------------
// itmq_pkg
// Shared constants, codes and controller/datapath interface types for the
// indexed tournament min queue.
//------------------------------------------------------------------------------
`default_nettype none

package itmq_pkg;

   localparam int SLOTS  = 64;
   localparam int NODES  = 2 * SLOTS;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int NODE_W = $clog2(NODES);
   localparam int OWN_W  = $clog2(SLOTS + 1);
   localparam int KEY_W  = 63;

   // Keys at or above this value mark an empty slot.
   localparam logic signed [KEY_W-1:0] LIMIT_KEY = 63'sd4000000000000000000;

   localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
   localparam logic [OWN_W-1:0]  NO_OWNER  = '0;

   typedef enum logic [1:0] {
      ACT_PUSH     = 2'd0,
      ACT_DECREASE = 2'd1,
      ACT_POP      = 2'd2
   } action_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;     // latch the request and set the node pointer
      logic rd_cur;     // read the node under the pointer
      logic leaf_wr;    // write the leaf, read its sibling
      logic climb;      // write the winner into the parent, move up
      logic dec_wr;     // overwrite the node with the new key, move up
      logic rsp_load;   // capture the root into the result registers
      logic pop_load;   // retarget the pointer at the popped slot's leaf
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic climb_last; // parent of the pointer is the root
      logic at_root;    // pointer is at the root
      logic dec_hit;    // node key read is above the new key
      logic root_empty; // root read has no owner
   } status_type;

endpackage

`default_nettype wire

[hw/rtl/itmq_datapath.sv]
//------------------------------------------------------------------------------
// itmq_datapath
// Node memory, valid bits, node pointer, winner comparison and result
// registers of the tournament tree.
//------------------------------------------------------------------------------
`default_nettype none

module itmq_datapath (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire itmq_pkg::cmd_type                       cmd,
   output      itmq_pkg::status_type                    status,
   input  wire logic [1:0]                              req_action,
   input  wire logic [itmq_pkg::SLOT_W-1:0]             req_slot,
   input  wire logic signed [itmq_pkg::KEY_W-1:0]       req_key,
   output      logic signed [itmq_pkg::KEY_W-1:0]       rsp_min_key,
   output      logic [itmq_pkg::SLOT_W-1:0]             rsp_min_slot,
   output      logic                                    rsp_empty_res
);

   // Node storage; a node whose valid bit is clear reads as limit, no owner.
   logic signed [itmq_pkg::KEY_W-1:0] key_mem [itmq_pkg::NODES];
   logic [itmq_pkg::OWN_W-1:0]        own_mem [itmq_pkg::NODES];
   logic [itmq_pkg::NODES-1:0]        valid_ff;

   logic signed [itmq_pkg::KEY_W-1:0] mem_key_ff;
   logic [itmq_pkg::OWN_W-1:0]        mem_own_ff;
   logic                              mem_vld_ff;
   logic signed [itmq_pkg::KEY_W-1:0] rd_key;
   logic [itmq_pkg::OWN_W-1:0]        rd_own;

   logic [itmq_pkg::NODE_W-1:0]       p_ff, p_in;
   logic [itmq_pkg::NODE_W-1:0]       parent;
   logic [itmq_pkg::SLOT_W-1:0]       slot_ff, slot_in;
   logic signed [itmq_pkg::KEY_W-1:0] key_ff, key_in;
   logic signed [itmq_pkg::KEY_W-1:0] cur_key_ff, cur_key_in;
   logic [itmq_pkg::OWN_W-1:0]        cur_own_ff, cur_own_in;

   logic signed [itmq_pkg::KEY_W-1:0] rsp_key_ff;
   logic [itmq_pkg::SLOT_W-1:0]       rsp_slot_ff;
   logic                              rsp_empty_ff;

   logic                              rd_en;
   logic [itmq_pkg::NODE_W-1:0]       rd_addr;
   logic                              wr_en;
   logic [itmq_pkg::NODE_W-1:0]       wr_addr;
   logic signed [itmq_pkg::KEY_W-1:0] wr_key;
   logic [itmq_pkg::OWN_W-1:0]        wr_own;

   logic signed [itmq_pkg::KEY_W-1:0] leaf_key;
   logic [itmq_pkg::OWN_W-1:0]        leaf_own;
   logic [itmq_pkg::OWN_W-1:0]        slot_own;
   logic                              sib_less;
   logic signed [itmq_pkg::KEY_W-1:0] win_key;
   logic [itmq_pkg::OWN_W-1:0]        win_own;
   logic [itmq_pkg::NODE_W-1:0]       req_leaf;
   logic [itmq_pkg::NODE_W-1:0]       pop_leaf;
   logic [itmq_pkg::OWN_W-1:0]        rd_own_m1;

   assign rd_key = mem_vld_ff ? mem_key_ff : itmq_pkg::LIMIT_KEY;
   assign rd_own = mem_vld_ff ? mem_own_ff : itmq_pkg::NO_OWNER;

   assign parent    = p_ff >> 1;
   assign slot_own  = itmq_pkg::OWN_W'(slot_ff) + itmq_pkg::OWN_W'(1);
   assign req_leaf  = itmq_pkg::NODE_W'(itmq_pkg::SLOTS) + itmq_pkg::NODE_W'(req_slot);
   assign rd_own_m1 = rd_own - itmq_pkg::OWN_W'(1);
   assign pop_leaf  = itmq_pkg::NODE_W'(itmq_pkg::SLOTS)
                    + itmq_pkg::NODE_W'(rd_own_m1[itmq_pkg::SLOT_W-1:0]);

   // A key at or above the limit is stored as an empty leaf.
   always_comb begin
      if (key_ff >= itmq_pkg::LIMIT_KEY) begin
         leaf_key = itmq_pkg::LIMIT_KEY;
         leaf_own = itmq_pkg::NO_OWNER;
      end else begin
         leaf_key = key_ff;
         leaf_own = slot_own;
      end
   end

   // Order by key, then by owner; no owner sorts below every slot.
   assign sib_less = (rd_key < cur_key_ff) ||
                     ((rd_key == cur_key_ff) && (rd_own < cur_own_ff));
   assign win_key  = sib_less ? rd_key : cur_key_ff;
   assign win_own  = sib_less ? rd_own : cur_own_ff;

   // Memory port selection.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = p_ff;
      wr_en   = 1'b0;
      wr_addr = p_ff;
      wr_key  = leaf_key;
      wr_own  = leaf_own;
      if (cmd.rd_cur) begin
         rd_en = 1'b1;
      end
      if (cmd.leaf_wr) begin
         rd_en   = 1'b1;
         rd_addr = p_ff ^ itmq_pkg::NODE_W'(1);
         wr_en   = 1'b1;
      end
      if (cmd.climb) begin
         rd_en   = 1'b1;
         rd_addr = parent ^ itmq_pkg::NODE_W'(1);
         wr_en   = 1'b1;
         wr_addr = parent;
         wr_key  = win_key;
         wr_own  = win_own;
      end
      if (cmd.dec_wr) begin
         rd_en   = 1'b1;
         rd_addr = parent;
         wr_en   = 1'b1;
         wr_key  = key_ff;
         wr_own  = slot_own;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         own_mem[wr_addr] <= wr_own;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_key_ff <= key_mem[rd_addr];
         mem_own_ff <= own_mem[rd_addr];
         mem_vld_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Pointer and operand registers.
   always_comb begin
      p_in       = p_ff;
      slot_in    = slot_ff;
      key_in     = key_ff;
      cur_key_in = cur_key_ff;
      cur_own_in = cur_own_ff;
      if (cmd.accept) begin
         slot_in = req_slot;
         key_in  = req_key;
         p_in    = (req_action == itmq_pkg::ACT_POP) ? itmq_pkg::ROOT_NODE : req_leaf;
      end
      if (cmd.leaf_wr) begin
         cur_key_in = leaf_key;
         cur_own_in = leaf_own;
      end
      if (cmd.climb) begin
         cur_key_in = win_key;
         cur_own_in = win_own;
         p_in       = parent;
      end
      if (cmd.dec_wr) begin
         p_in = parent;
      end
      if (cmd.pop_load) begin
         p_in    = pop_leaf;
         slot_in = rd_own_m1[itmq_pkg::SLOT_W-1:0];
         key_in  = itmq_pkg::LIMIT_KEY;
      end
   end

   always_ff @(posedge clock) begin
      p_ff       <= p_in;
      slot_ff    <= slot_in;
      key_ff     <= key_in;
      cur_key_ff <= cur_key_in;
      cur_own_ff <= cur_own_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_empty_ff <= status.root_empty;
         rsp_key_ff   <= status.root_empty ? itmq_pkg::LIMIT_KEY : rd_key;
         rsp_slot_ff  <= status.root_empty ? '0 : rd_own_m1[itmq_pkg::SLOT_W-1:0];
      end
   end

   assign rsp_min_key   = rsp_key_ff;
   assign rsp_min_slot  = rsp_slot_ff;
   assign rsp_empty_res = rsp_empty_ff;

   assign status.climb_last = (parent == itmq_pkg::ROOT_NODE);
   assign status.at_root    = (p_ff == itmq_pkg::ROOT_NODE);
   assign status.dec_hit    = (rd_key > key_ff);
   assign status.root_empty = (rd_own == itmq_pkg::NO_OWNER);

`ifndef NO_ASSERTIONS
   // A climb step always has a real parent to write.
   a_climb_parent: assert property (@(posedge clock) disable iff (reset)
      cmd.climb |-> (parent != '0))
      else $error("climb issued with no parent node");

   // Decrease key never writes the unused node zero.
   a_dec_node: assert property (@(posedge clock) disable iff (reset)
      cmd.dec_wr |-> (p_ff != '0))
      else $error("decrease key wrote node zero");

   // A delete after pop only targets an owned root.
   a_pop_owner: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_load |-> (rd_own != itmq_pkg::NO_OWNER))
      else $error("pop delete without an owner");

   // After a climb the pointer is the parent of the previous pointer.
   a_climb_moves: assert property (@(posedge clock) disable iff (reset)
      cmd.climb |=> (p_ff == ($past(p_ff) >> 1)))
      else $error("climb did not move the pointer up one level");
`endif

endmodule

`default_nettype wire

[hw/rtl/itmq_ctrl.sv]
//------------------------------------------------------------------------------
// itmq_ctrl
// Sequencer for push, decrease key and pop, plus the result handshake.
//------------------------------------------------------------------------------
`default_nettype none

module itmq_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [1:0]            req_action,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      itmq_pkg::cmd_type     cmd,
   input  wire itmq_pkg::status_type  status
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_LEAF  = 7'b0000010,
      ST_CLIMB = 7'b0000100,
      ST_DRD   = 7'b0001000,
      ST_DEC   = 7'b0010000,
      ST_PRD   = 7'b0100000,
      ST_ROOT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_action)
                  itmq_pkg::ACT_PUSH:     state_in = ST_LEAF;
                  itmq_pkg::ACT_DECREASE: state_in = ST_DRD;
                  itmq_pkg::ACT_POP:      state_in = ST_PRD;
                  default:                state_in = ST_IDLE;
               endcase
            end
         end
         ST_LEAF: begin
            cmd.leaf_wr = 1'b1;
            state_in    = ST_CLIMB;
         end
         ST_CLIMB: begin
            cmd.climb = 1'b1;
            if (status.climb_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_DRD: begin
            cmd.rd_cur = 1'b1;
            state_in   = ST_DEC;
         end
         ST_DEC: begin
            if (status.dec_hit) begin
               cmd.dec_wr = 1'b1;
               if (status.at_root) begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PRD: begin
            cmd.rd_cur = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               if (status.root_empty) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.pop_load = 1'b1;
                  state_in     = ST_LEAF;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   // A new result is never loaded over one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> rsp_free)
      else $error("result overwritten before transfer");

   // The tree walk after a leaf write always starts with a climb.
   a_leaf_then_climb: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEAF) |=> (state_ff == ST_CLIMB))
      else $error("leaf write not followed by climb");

   // Only an owned root starts a delete.
   a_pop_delete: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_load |-> (cmd.rsp_load && !status.root_empty))
      else $error("delete started without a reported minimum");
`endif

endmodule

`default_nettype wire

[hw/rtl/indexed_tournament_min_queue.sv]
//------------------------------------------------------------------------------
// indexed_tournament_min_queue
// Indexed min priority queue over 64 slots kept as a tournament tree.
//------------------------------------------------------------------------------
// Usage: a request transfer on the req_ channel carries an action, a slot and
// a signed 63-bit key. Push sets the key of a slot (a key at or above the
// limit empties the slot), decrease key lowers the nodes on the slot's path
// while they hold a larger key, and pop returns the minimum on the rsp_
// channel and then empties its slot. Only pop produces a response transfer;
// a pop on an empty queue reports the limit key, slot zero and empty_res set.
// Ties between equal keys go to the lower slot where push and pop walks compare.
// Timing: the node memory has one write and one registered read port, and
// the sequencer walks one tree level per cycle over it. A push steps through
// accept, leaf write and a climb over six levels. A decrease key reads the
// leaf, then overwrites nodes upward while they hold a larger key, up to the
// root. A pop accepts, reads the root, loads the response once the output
// register is free and, on a non-empty queue, runs the push walk on the
// popped slot's leaf with the limit key. One request is in work at a time.
// Reset clears every node to the empty state at once through per-node valid
// bits; the block accepts requests in the first cycle after reset. When the
// receiver stalls, the response is held in its output register while the
// block goes on accepting pushes and decrease keys; a following pop waits
// at its root read until the held response is transferred.
//------------------------------------------------------------------------------
`default_nettype none

module indexed_tournament_min_queue (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_ready,
   input  wire logic [1:0]                         req_action,
   input  wire logic [itmq_pkg::SLOT_W-1:0]        req_slot,
   input  wire logic signed [itmq_pkg::KEY_W-1:0]  req_key,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   output      logic signed [itmq_pkg::KEY_W-1:0]  rsp_min_key,
   output      logic [itmq_pkg::SLOT_W-1:0]        rsp_min_slot,
   output      logic                               rsp_empty_res
);

   // Commands and status between the sequencer and the tree datapath.
   itmq_pkg::cmd_type    cmd;
   itmq_pkg::status_type status;

   itmq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .status     (status)
   );

   // The datapath holds the node memory and the result registers.
   itmq_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_action    (req_action),
      .req_slot      (req_slot),
      .req_key       (req_key),
      .rsp_min_key   (rsp_min_key),
      .rsp_min_slot  (rsp_min_slot),
      .rsp_empty_res (rsp_empty_res)
   );

endmodule

`default_nettype wire
